// ===== hw/rtl/tlvid_pkg.sv =====
// Shared types and codes for the image directory parser.
`default_nettype none

package tlvid_pkg;

  // Result kinds
  localparam logic [1:0] KIND_NAME  = 2'd0;
  localparam logic [1:0] KIND_FILE  = 2'd1;
  localparam logic [1:0] KIND_ERROR = 2'd2;

  // Mount error codes
  localparam logic [2:0] ERR_BAD_HEADER  = 3'd0;
  localparam logic [2:0] ERR_NO_VERSION  = 3'd1;
  localparam logic [2:0] ERR_NO_HSIZE    = 3'd2;
  localparam logic [2:0] ERR_NO_COUNT    = 3'd3;
  localparam logic [2:0] ERR_TOO_MANY    = 3'd4;
  localparam logic [2:0] ERR_BAD_FILE    = 3'd5;

  // Record types and fixed values
  localparam logic [7:0]  TYPE_MAGIC   = 8'd1;
  localparam logic [7:0]  TYPE_VERSION = 8'd2;
  localparam logic [7:0]  TYPE_HSIZE   = 8'd3;
  localparam logic [7:0]  TYPE_COUNT   = 8'd4;
  localparam logic [7:0]  TYPE_END     = 8'hFE;
  localparam logic [31:0] MAGIC_PAIR   = 32'hA55A_A55A;
  localparam logic [15:0] MAX_FILES_RST = 16'd1024;

  typedef struct packed {
    logic [1:0]  result_kind;
    logic [15:0] file_number;
    logic [7:0]  name_char;
    logic [7:0]  name_length;
    logic [31:0] file_length;
    logic [31:0] data_offset;
    logic [15:0] image_version;
    logic        mount_done;
    logic [2:0]  error_code;
  } result_t;

endpackage

`default_nettype wire

// ===== hw/rtl/tlv_image_directory_parser_core.sv =====
// Streaming parser for a type/length image directory: top level.
//
// Usage: image bytes enter one per transfer on the in_ channel; in_image_start
// marks the first byte of an image and restarts the parser at that byte. Bytes
// seen while no image is open are dropped. Each accepted byte produces at most
// one result on the out_ channel: a name byte, a completed file entry (size,
// data offset, version, last-file flag) or a mount error, after which the
// parser idles until the next start byte.
// Latency: a result is presented in the cycle after the byte that causes it.
// Throughput: one byte per cycle unless stalled; all per-byte work is one pass
// through the phase decoder between the parser state and the result register.
// Stall: in_stall is raised only while the result register holds a result
// and out_stall is high; it holds the input until the result is taken.
// Reset (rst_n low, synchronous): parser idle, result register empty,
// max_file_count back to 1024. The cfg_ channel (always ready) writes
// max_file_count; write it only while the parser is idle.
`default_nettype none

module tlv_image_directory_parser_core import tlvid_pkg::*; #(
  parameter int MAX_HEADER_RECORDS = 128
) (
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire logic        cfg_valid,
  output logic             cfg_ready,
  input  wire logic [15:0] cfg_max_file_count,
  input  wire logic        in_valid,
  output logic             in_stall,
  input  wire logic [7:0]  in_image_byte,
  input  wire logic        in_image_start,
  output logic             out_valid,
  input  wire logic        out_stall,
  output logic [1:0]       out_result_kind,
  output logic [15:0]      out_file_number,
  output logic [7:0]       out_name_char,
  output logic [7:0]       out_name_length,
  output logic [31:0]      out_file_length,
  output logic [31:0]      out_data_offset,
  output logic [15:0]      out_image_version,
  output logic             out_mount_done,
  output logic [2:0]       out_error_code
);

  localparam int HCNT_W = $clog2(MAX_HEADER_RECORDS + 1);
  localparam logic [HCNT_W-1:0] HCNT_MAX = HCNT_W'(MAX_HEADER_RECORDS);

  localparam logic [4:0] PH_IDLE    = 5'd0;
  localparam logic [4:0] PH_H_TYPE  = 5'd1;
  localparam logic [4:0] PH_H_LEN   = 5'd2;
  localparam logic [4:0] PH_H_MAGIC = 5'd3;
  localparam logic [4:0] PH_H_VER   = 5'd4;
  localparam logic [4:0] PH_H_HSIZE = 5'd5;
  localparam logic [4:0] PH_H_COUNT = 5'd6;
  localparam logic [4:0] PH_H_SKIP  = 5'd7;
  localparam logic [4:0] PH_H_CRC   = 5'd8;
  localparam logic [4:0] PH_F_TYPE1 = 5'd9;
  localparam logic [4:0] PH_F_LEN1  = 5'd10;
  localparam logic [4:0] PH_F_MAGIC = 5'd11;
  localparam logic [4:0] PH_F_TYPE2 = 5'd12;
  localparam logic [4:0] PH_F_LEN2  = 5'd13;
  localparam logic [4:0] PH_F_NAME  = 5'd14;
  localparam logic [4:0] PH_F_TYPE3 = 5'd15;
  localparam logic [4:0] PH_F_LEN3  = 5'd16;
  localparam logic [4:0] PH_F_SIZE  = 5'd17;
  localparam logic [4:0] PH_F_TYPE4 = 5'd18;
  localparam logic [4:0] PH_F_LEN4  = 5'd19;
  localparam logic [4:0] PH_F_CHECK = 5'd20;
  localparam logic [4:0] PH_F_DATA  = 5'd21;

  // parser state
  logic [4:0]        phase_r, phase_nxt;
  logic [31:0]       pos_r, pos_nxt;
  logic [7:0]        rtype_r, rtype_nxt;
  logic [31:0]       left_r, left_nxt;
  logic [31:0]       acc_r, acc_nxt;
  logic [HCNT_W-1:0] hcnt_r, hcnt_nxt;
  logic [15:0]       version_r, version_nxt;
  logic              hsize_nz_r, hsize_nz_nxt;
  logic [15:0]       ftotal_r, ftotal_nxt;
  logic [15:0]       cur_file_r, cur_file_nxt;
  logic [31:0]       size_r, size_nxt;
  logic [7:0]        name_len_r, name_len_nxt;
  logic [15:0]       max_files_r;

  // state as seen by this byte (a start byte resets it first)
  logic [4:0]        cur_phase;
  logic [31:0]       cur_pos, cur_left, cur_acc, cur_size;
  logic [7:0]        cur_rtype, cur_name_len;
  logic [HCNT_W-1:0] cur_hcnt, hcnt_inc;
  logic [15:0]       cur_version, cur_ftotal, cur_file, file_inc;
  logic              cur_hsize_nz;
  logic [31:0]       acc_shift, left_dec;

  logic        in_fire;
  logic        hdr_next, fail_hit, res_valid;
  logic [2:0]  fail_code;
  result_t     res, out_res_r;
  logic        out_valid_r;

  assign cfg_ready = 1'b1;
  assign in_stall  = out_valid_r & out_stall;
  assign in_fire   = in_valid & ~in_stall;

  assign cur_phase    = in_image_start ? PH_H_TYPE : phase_r;
  assign cur_pos      = in_image_start ? '0 : pos_r;
  assign cur_rtype    = in_image_start ? '0 : rtype_r;
  assign cur_left     = in_image_start ? '0 : left_r;
  assign cur_acc      = in_image_start ? '0 : acc_r;
  assign cur_hcnt     = in_image_start ? '0 : hcnt_r;
  assign cur_version  = in_image_start ? '0 : version_r;
  assign cur_hsize_nz = in_image_start ? 1'b0 : hsize_nz_r;
  assign cur_ftotal   = in_image_start ? '0 : ftotal_r;
  assign cur_file     = in_image_start ? '0 : cur_file_r;
  assign cur_size     = in_image_start ? '0 : size_r;
  assign cur_name_len = in_image_start ? '0 : name_len_r;

  assign acc_shift = {in_image_byte, cur_acc[31:8]};
  assign left_dec  = cur_left - 32'd1;
  assign hcnt_inc  = cur_hcnt + 1'b1;
  assign file_inc  = cur_file + 16'd1;

  always_comb begin
    phase_nxt    = cur_phase;
    pos_nxt      = cur_pos;
    rtype_nxt    = cur_rtype;
    left_nxt     = cur_left;
    acc_nxt      = cur_acc;
    hcnt_nxt     = cur_hcnt;
    version_nxt  = cur_version;
    hsize_nz_nxt = cur_hsize_nz;
    ftotal_nxt   = cur_ftotal;
    cur_file_nxt = cur_file;
    size_nxt     = cur_size;
    name_len_nxt = cur_name_len;
    hdr_next     = 1'b0;
    fail_hit     = 1'b0;
    fail_code    = ERR_BAD_HEADER;
    res_valid    = 1'b0;
    res          = '0;

    if (cur_phase != PH_IDLE) begin
      pos_nxt = cur_pos + 32'd1;
      unique case (cur_phase)
        PH_H_TYPE: begin
          rtype_nxt = in_image_byte;
          phase_nxt = PH_H_LEN;
        end
        PH_H_LEN: begin
          priority if (cur_rtype == TYPE_MAGIC || cur_rtype == TYPE_HSIZE) begin
            if (in_image_byte != 8'd4) begin
              fail_hit = 1'b1;
            end else begin
              left_nxt  = 32'd4;
              acc_nxt   = '0;
              phase_nxt = (cur_rtype == TYPE_MAGIC) ? PH_H_MAGIC : PH_H_HSIZE;
            end
          end else if (cur_rtype == TYPE_VERSION || cur_rtype == TYPE_COUNT) begin
            if (in_image_byte != 8'd2) begin
              fail_hit = 1'b1;
            end else begin
              left_nxt  = 32'd2;
              acc_nxt   = '0;
              phase_nxt = (cur_rtype == TYPE_VERSION) ? PH_H_VER : PH_H_COUNT;
            end
          end else if (cur_rtype == TYPE_END) begin
            fail_hit = 1'b1;
            priority if (in_image_byte != 8'd2) fail_code = ERR_BAD_HEADER;
            else if (cur_version == 16'd0)      fail_code = ERR_NO_VERSION;
            else if (!cur_hsize_nz)             fail_code = ERR_NO_HSIZE;
            else if (cur_ftotal == 16'd0)       fail_code = ERR_NO_COUNT;
            else if (cur_ftotal > max_files_r)  fail_code = ERR_TOO_MANY;
            else begin
              fail_hit  = 1'b0;
              left_nxt  = 32'd2;
              phase_nxt = PH_H_CRC;
            end
          end else begin
            if (in_image_byte == 8'd0) begin
              hdr_next = 1'b1;
            end else begin
              left_nxt  = {24'd0, in_image_byte};
              phase_nxt = PH_H_SKIP;
            end
          end
        end
        PH_H_MAGIC, PH_H_VER, PH_H_HSIZE, PH_H_COUNT: begin
          acc_nxt  = acc_shift;
          left_nxt = left_dec;
          if (left_dec == 32'd0) begin
            unique case (cur_phase)
              PH_H_MAGIC: begin
                if (acc_shift != MAGIC_PAIR) fail_hit = 1'b1;
                else hdr_next = 1'b1;
              end
              PH_H_VER: begin
                version_nxt = acc_shift[31:16];
                hdr_next    = 1'b1;
              end
              PH_H_HSIZE: begin
                hsize_nz_nxt = (acc_shift != 32'd0);
                hdr_next     = 1'b1;
              end
              default: begin
                ftotal_nxt = acc_shift[31:16];
                hdr_next   = 1'b1;
              end
            endcase
          end
        end
        PH_H_SKIP: begin
          left_nxt = left_dec;
          if (left_dec == 32'd0) hdr_next = 1'b1;
        end
        PH_H_CRC: begin
          left_nxt = left_dec;
          if (left_dec == 32'd0) begin
            cur_file_nxt = '0;
            phase_nxt    = PH_F_TYPE1;
          end
        end
        PH_F_TYPE1, PH_F_TYPE2, PH_F_TYPE3, PH_F_TYPE4: begin
          rtype_nxt = in_image_byte;
          phase_nxt = cur_phase + 5'd1;
        end
        PH_F_LEN1: begin
          if (cur_rtype != TYPE_MAGIC || in_image_byte != 8'd4) begin
            fail_hit  = 1'b1;
            fail_code = ERR_BAD_FILE;
          end else begin
            left_nxt  = 32'd4;
            phase_nxt = PH_F_MAGIC;
          end
        end
        PH_F_MAGIC: begin
          left_nxt = left_dec;
          if (left_dec == 32'd0) phase_nxt = PH_F_TYPE2;
        end
        PH_F_LEN2: begin
          if (cur_rtype != TYPE_VERSION) begin
            fail_hit  = 1'b1;
            fail_code = ERR_BAD_FILE;
          end else begin
            name_len_nxt = in_image_byte;
            left_nxt     = {24'd0, in_image_byte};
            phase_nxt    = (in_image_byte != 8'd0) ? PH_F_NAME : PH_F_TYPE3;
          end
        end
        PH_F_NAME: begin
          res_valid       = 1'b1;
          res.result_kind = KIND_NAME;
          res.file_number = cur_file;
          res.name_char   = in_image_byte;
          left_nxt        = left_dec;
          if (left_dec == 32'd0) phase_nxt = PH_F_TYPE3;
        end
        PH_F_LEN3: begin
          if (cur_rtype != TYPE_HSIZE || in_image_byte != 8'd4) begin
            fail_hit  = 1'b1;
            fail_code = ERR_BAD_FILE;
          end else begin
            left_nxt  = 32'd4;
            acc_nxt   = '0;
            phase_nxt = PH_F_SIZE;
          end
        end
        PH_F_SIZE: begin
          acc_nxt  = acc_shift;
          left_nxt = left_dec;
          if (left_dec == 32'd0) begin
            size_nxt  = acc_shift;
            phase_nxt = PH_F_TYPE4;
          end
        end
        PH_F_LEN4: begin
          if (cur_rtype != TYPE_END || in_image_byte != 8'd2) begin
            fail_hit  = 1'b1;
            fail_code = ERR_BAD_FILE;
          end else begin
            left_nxt  = 32'd2;
            phase_nxt = PH_F_CHECK;
          end
        end
        PH_F_CHECK: begin
          left_nxt = left_dec;
          if (left_dec == 32'd0) begin
            res_valid         = 1'b1;
            res.result_kind   = KIND_FILE;
            res.file_number   = cur_file;
            res.name_length   = cur_name_len;
            res.file_length   = cur_size;
            res.data_offset   = cur_pos + 32'd1;
            res.image_version = cur_version;
            res.mount_done    = (file_inc == cur_ftotal);
            if (file_inc == cur_ftotal) begin
              phase_nxt = PH_IDLE;
            end else begin
              cur_file_nxt = file_inc;
              left_nxt     = cur_size;
              phase_nxt    = (cur_size != 32'd0) ? PH_F_DATA : PH_F_TYPE1;
            end
          end
        end
        PH_F_DATA: begin
          left_nxt = left_dec;
          if (left_dec == 32'd0) phase_nxt = PH_F_TYPE1;
        end
        default: phase_nxt = PH_IDLE;
      endcase
    end

    // close of one header record
    if (hdr_next) begin
      hcnt_nxt = hcnt_inc;
      if (hcnt_inc >= HCNT_MAX) fail_hit = 1'b1;
      else phase_nxt = PH_H_TYPE;
    end

    if (fail_hit) begin
      phase_nxt       = PH_IDLE;
      res_valid       = 1'b1;
      res             = '0;
      res.result_kind = KIND_ERROR;
      res.file_number = cur_file;
      res.error_code  = fail_code;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r    <= PH_IDLE;
      pos_r      <= '0;
      rtype_r    <= '0;
      left_r     <= '0;
      acc_r      <= '0;
      hcnt_r     <= '0;
      version_r  <= '0;
      hsize_nz_r <= 1'b0;
      ftotal_r   <= '0;
      cur_file_r <= '0;
      size_r     <= '0;
      name_len_r <= '0;
    end else if (in_fire) begin
      phase_r    <= phase_nxt;
      pos_r      <= pos_nxt;
      rtype_r    <= rtype_nxt;
      left_r     <= left_nxt;
      acc_r      <= acc_nxt;
      hcnt_r     <= hcnt_nxt;
      version_r  <= version_nxt;
      hsize_nz_r <= hsize_nz_nxt;
      ftotal_r   <= ftotal_nxt;
      cur_file_r <= cur_file_nxt;
      size_r     <= size_nxt;
      name_len_r <= name_len_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      max_files_r <= MAX_FILES_RST;
    end else if (cfg_valid && cfg_ready) begin
      max_files_r <= cfg_max_file_count;
    end
  end

  // result register; in_stall guarantees it is free or draining on a new result
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (in_fire && res_valid) begin
      out_valid_r <= 1'b1;
    end else if (!out_stall) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (in_fire && res_valid) begin
      out_res_r <= res;
    end
  end

  assign out_valid         = out_valid_r;
  assign out_result_kind   = out_res_r.result_kind;
  assign out_file_number   = out_res_r.file_number;
  assign out_name_char     = out_res_r.name_char;
  assign out_name_length   = out_res_r.name_length;
  assign out_file_length   = out_res_r.file_length;
  assign out_data_offset   = out_res_r.data_offset;
  assign out_image_version = out_res_r.image_version;
  assign out_mount_done    = out_res_r.mount_done;
  assign out_error_code    = out_res_r.error_code;

endmodule

`default_nettype wire

// ===== hw/rtl/tlvid_checker.sv =====
// Port-level checker for the image directory parser, bound to the top level.
`default_nettype none

module tlvid_checker import tlvid_pkg::*; (
  input wire logic        clk,
  input wire logic        rst_n,
  input wire logic        in_stall,
  input wire logic        out_valid,
  input wire logic        out_stall,
  input wire logic [1:0]  out_result_kind,
  input wire logic [15:0] out_file_number,
  input wire logic [7:0]  out_name_char,
  input wire logic [7:0]  out_name_length,
  input wire logic [31:0] out_file_length,
  input wire logic [31:0] out_data_offset,
  input wire logic        out_mount_done,
  input wire logic [2:0]  out_error_code
);

  // a held result keeps its payload
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_stall |=> out_valid && $stable(out_file_number) &&
      $stable(out_name_char) && $stable(out_data_offset) && $stable(out_result_kind))
    else $error("stalled result changed");

  // input is only held back by a pending result
  a_stall_cause: assert property (@(posedge clk) disable iff (!rst_n)
    in_stall |-> out_valid && out_stall)
    else $error("input stalled without pending result");

  a_reset_empty: assert property (@(posedge clk)
    $past(!rst_n) |-> !out_valid)
    else $error("result valid right after reset");

  a_name_clean: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_result_kind == KIND_NAME |->
      out_name_length == 8'd0 && out_file_length == 32'd0 &&
      !out_mount_done && out_error_code == ERR_BAD_HEADER)
    else $error("name transfer carries entry fields");

  a_error_clean: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_result_kind == KIND_ERROR |->
      !out_mount_done && out_error_code <= ERR_BAD_FILE && out_name_char == 8'd0)
    else $error("malformed error transfer");

endmodule

bind tlv_image_directory_parser_core tlvid_checker u_tlvid_checker (.*);

`default_nettype wire
